FILE: hdl/nrm_pkg.sv
`default_nettype none

package nrm_pkg;

	localparam int MAX_ROWS = 64;
	localparam int MAX_COLS = 64;

	localparam int ELEM_W = 16;
	localparam int MAG_W  = 16;
	localparam int SUM_W  = 22;
	localparam int SQ_W   = 43;
	localparam int ROOT_W = 22;
	localparam int PROD_W = 2 * MAG_W;

	localparam int COL_AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int ROW_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CNT_W  = 7;

	localparam int MODE_W = 2;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;
	localparam int RIDX_W = ADDR_W - 2;

	typedef enum logic [MODE_W-1:0] {
		MODE_ONE = 2'd0,
		MODE_INF = 2'd1,
		MODE_FRO = 2'd2
	} norm_mode_t;

	typedef enum logic [RIDX_W-1:0] {
		REG_NORM_MODE = 2'd0,
		REG_ROW_COUNT = 2'd1,
		REG_COL_COUNT = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic              rd_en;
		logic [COL_AW-1:0] rd_addr;
		logic              upd_en;
		logic [MAG_W-1:0]  mag;
		logic              clear;
	} colsum_ctl_t;

	function automatic logic [CNT_W-1:0] clamp_count(
		input logic [CNT_W-1:0] v,
		input logic [CNT_W-1:0] maxv
	);
		logic [CNT_W-1:0] r;
		if (v == '0) begin
			r = CNT_W'(1);
		end else if (v > maxv) begin
			r = maxv;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: hdl/nrm_colsum.sv
`default_nettype none

module nrm_colsum (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire nrm_pkg::colsum_ctl_t     ctl,
	output logic [nrm_pkg::SUM_W-1:0]     colmax_nx
);

	logic [nrm_pkg::SUM_W-1:0]  mem [nrm_pkg::MAX_COLS];
	logic [nrm_pkg::SUM_W-1:0]  rdata_s1;
	logic [nrm_pkg::COL_AW-1:0] addr_s1;
	logic [nrm_pkg::MAX_COLS-1:0] vld_q;
	logic                       wr_q;
	logic [nrm_pkg::COL_AW-1:0] wr_addr_q;
	logic [nrm_pkg::SUM_W-1:0]  wr_data_q;
	logic [nrm_pkg::SUM_W-1:0]  colmax_q;
	logic [nrm_pkg::SUM_W-1:0]  base;
	logic [nrm_pkg::SUM_W-1:0]  sum_new;

	always_comb begin
		if (wr_q && (wr_addr_q == addr_s1)) begin
			base = wr_data_q;
		end else if (vld_q[addr_s1]) begin
			base = rdata_s1;
		end else begin
			base = '0;
		end
		sum_new   = base + nrm_pkg::SUM_W'(ctl.mag);
		colmax_nx = (sum_new > colmax_q) ? sum_new : colmax_q;
	end

	always_ff @(posedge clk) begin
		if (ctl.upd_en) begin
			mem[addr_s1] <= sum_new;
		end
		if (ctl.rd_en) begin
			rdata_s1 <= mem[ctl.rd_addr];
			addr_s1  <= ctl.rd_addr;
		end
		wr_addr_q <= addr_s1;
		wr_data_q <= sum_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			wr_q     <= 1'b0;
			colmax_q <= '0;
		end else if (ctl.clear) begin
			vld_q    <= '0;
			wr_q     <= 1'b0;
			colmax_q <= '0;
		end else begin
			wr_q <= ctl.upd_en;
			if (ctl.upd_en) begin
				vld_q[addr_s1] <= 1'b1;
				colmax_q       <= colmax_nx;
			end
		end
	end

endmodule

`default_nettype wire

FILE: hdl/nrm_sqrt.sv
`default_nettype none

module nrm_sqrt (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     go,
	input  wire logic [nrm_pkg::SQ_W-1:0] radicand,
	output logic                          busy,
	output logic                          done,
	output logic [nrm_pkg::ROOT_W-1:0]    root
);

	localparam int RAD_W = 2 * nrm_pkg::ROOT_W;
	localparam int REM_W = nrm_pkg::ROOT_W + 2;
	localparam int ITW   = $clog2(nrm_pkg::ROOT_W);

	logic [RAD_W-1:0]          rad_q;
	logic [REM_W-1:0]          rem_q;
	logic [nrm_pkg::ROOT_W-1:0] root_q;
	logic [ITW-1:0]            cnt_q;
	logic                      run_q;
	logic                      done_q;
	logic [REM_W-1:0]          rem_sh;
	logic [REM_W-1:0]          trial;
	logic                      ge;

	always_comb begin
		rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
		trial  = {root_q, 2'b01};
		ge     = (rem_sh >= trial);
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rad_q  <= RAD_W'(radicand);
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q  <= ge ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[nrm_pkg::ROOT_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= ITW'(nrm_pkg::ROOT_W - 1);
			end else if (run_q) begin
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	assign busy = run_q;
	assign done = done_q;
	assign root = root_q;

endmodule

`default_nettype wire

FILE: hdl/matrix_norm_unit.sv
// Streaming matrix norm engine. Elements of a row_count x col_count matrix enter in row-major
// order, one signed Q8.8 element per transfer (start high while busy is low), one per clock
// within a matrix. Column sums live in a registered-read column memory that is updated by
// read-modify-write, with forwarding when one column is hit on consecutive clocks. After the
// last element busy stays high: for the 1-norm and infinity norm the result is registered
// from the element stage and strobes on done; for the Frobenius norm the square-root unit
// resolves one root bit per clock and done strobes after all 22 root bits. done is a
// single-cycle strobe with norm_value valid in that cycle; the receiver cannot stall it.
// Any write to a defined register abandons the matrix in progress; write only while idle.
`default_nettype none

module matrix_norm_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic signed [nrm_pkg::ELEM_W-1:0] element,
	output logic                                   busy,
	output logic                                   done,
	output logic [nrm_pkg::SUM_W-1:0]              norm_value,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [nrm_pkg::ADDR_W-1:0]        paddr,
	input  wire logic [nrm_pkg::DATA_W-1:0]        pwdata,
	output logic [nrm_pkg::DATA_W-1:0]             prdata,
	output logic                                   pready
);

	logic [nrm_pkg::MODE_W-1:0] norm_mode_q;
	logic [nrm_pkg::CNT_W-1:0]  row_count_q;
	logic [nrm_pkg::CNT_W-1:0]  col_count_q;
	logic [nrm_pkg::RIDX_W-1:0] reg_sel;
	logic                       cfg_wr;
	logic                       cfg_hit;
	logic                       cfg_clr;
	logic [nrm_pkg::DATA_W-1:0] rd_val;

	logic                       accept;
	logic [nrm_pkg::COL_AW-1:0] col_q;
	logic [nrm_pkg::ROW_AW-1:0] row_q;
	logic [nrm_pkg::CNT_W-1:0]  rows_eff;
	logic [nrm_pkg::CNT_W-1:0]  cols_eff;
	logic                       last_col;
	logic                       last_row;
	logic [nrm_pkg::MAG_W-1:0]  mag;

	logic                       vld_s1;
	logic [nrm_pkg::MAG_W-1:0]  mag_s1;
	logic                       last_col_s1;
	logic                       last_row_s1;

	logic [nrm_pkg::SUM_W-1:0]  row_sum_q;
	logic [nrm_pkg::SUM_W-1:0]  best_q;
	logic [nrm_pkg::SQ_W-1:0]   sq_q;
	logic [nrm_pkg::SUM_W-1:0]  row_new;
	logic [nrm_pkg::SUM_W-1:0]  best_nx;
	logic [nrm_pkg::PROD_W-1:0] sq_prod;
	logic [nrm_pkg::SQ_W-1:0]   sq_new;
	logic                       fin;
	logic                       clr;
	logic                       fro;

	logic [nrm_pkg::SUM_W-1:0]  colmax_nx;
	logic [nrm_pkg::SUM_W-1:0]  fast_val;
	logic [nrm_pkg::SUM_W-1:0]  res_q;
	logic                       done_fast_q;
	logic                       sq_busy;
	logic                       sq_done;
	logic [nrm_pkg::ROOT_W-1:0] sq_root;

	nrm_pkg::colsum_ctl_t       cs_ctl;

	assign pready  = 1'b1;
	assign reg_sel = paddr[nrm_pkg::ADDR_W-1:2];
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_clr = cfg_wr & cfg_hit;

	always_comb begin
		cfg_hit = 1'b0;
		rd_val  = '0;
		unique case (reg_sel)
			nrm_pkg::REG_NORM_MODE: begin
				cfg_hit = 1'b1;
				rd_val  = nrm_pkg::DATA_W'(norm_mode_q);
			end
			nrm_pkg::REG_ROW_COUNT: begin
				cfg_hit = 1'b1;
				rd_val  = nrm_pkg::DATA_W'(row_count_q);
			end
			nrm_pkg::REG_COL_COUNT: begin
				cfg_hit = 1'b1;
				rd_val  = nrm_pkg::DATA_W'(col_count_q);
			end
			default: begin
				cfg_hit = 1'b0;
			end
		endcase
	end

	assign prdata = rd_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			norm_mode_q <= nrm_pkg::MODE_W'(nrm_pkg::MODE_ONE);
			row_count_q <= nrm_pkg::CNT_W'(4);
			col_count_q <= nrm_pkg::CNT_W'(4);
		end else if (cfg_wr) begin
			unique case (reg_sel)
				nrm_pkg::REG_NORM_MODE: norm_mode_q <= pwdata[nrm_pkg::MODE_W-1:0];
				nrm_pkg::REG_ROW_COUNT: row_count_q <= pwdata[nrm_pkg::CNT_W-1:0];
				nrm_pkg::REG_COL_COUNT: col_count_q <= pwdata[nrm_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		rows_eff = nrm_pkg::clamp_count(row_count_q, nrm_pkg::CNT_W'(nrm_pkg::MAX_ROWS));
		cols_eff = nrm_pkg::clamp_count(col_count_q, nrm_pkg::CNT_W'(nrm_pkg::MAX_COLS));
		last_col = ((nrm_pkg::CNT_W'(col_q) + 1'b1) >= cols_eff);
		last_row = ((nrm_pkg::CNT_W'(row_q) + 1'b1) >= rows_eff);
		mag      = element[nrm_pkg::ELEM_W-1] ? nrm_pkg::MAG_W'(-element)
		                                      : nrm_pkg::MAG_W'(element);
	end

	assign accept = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			if (cfg_clr) begin
				col_q <= '0;
				row_q <= '0;
			end else if (accept) begin
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mag_s1      <= mag;
			last_col_s1 <= last_col;
			last_row_s1 <= last_row;
		end
	end

	always_comb begin
		sq_prod = nrm_pkg::PROD_W'(mag_s1) * nrm_pkg::PROD_W'(mag_s1);
		sq_new  = sq_q + nrm_pkg::SQ_W'(sq_prod);
		row_new = row_sum_q + nrm_pkg::SUM_W'(mag_s1);
		best_nx = (row_new > best_q) ? row_new : best_q;
		fin     = vld_s1 & last_col_s1 & last_row_s1;
		clr     = cfg_clr | fin;
		fro     = (norm_mode_q == nrm_pkg::MODE_FRO);
		case (norm_mode_q)
			nrm_pkg::MODE_ONE: fast_val = colmax_nx;
			nrm_pkg::MODE_INF: fast_val = best_nx;
			default:           fast_val = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_sum_q <= '0;
			best_q    <= '0;
			sq_q      <= '0;
		end else if (clr) begin
			row_sum_q <= '0;
			best_q    <= '0;
			sq_q      <= '0;
		end else if (vld_s1) begin
			sq_q <= sq_new;
			if (last_col_s1) begin
				row_sum_q <= '0;
				best_q    <= best_nx;
			end else begin
				row_sum_q <= row_new;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_fast_q <= 1'b0;
		end else begin
			done_fast_q <= fin & ~fro;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			res_q <= fast_val;
		end
	end

	always_comb begin
		cs_ctl.rd_en   = accept;
		cs_ctl.rd_addr = col_q;
		cs_ctl.upd_en  = vld_s1;
		cs_ctl.mag     = mag_s1;
		cs_ctl.clear   = clr;
	end

	nrm_colsum u_colsum (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (cs_ctl),
		.colmax_nx (colmax_nx)
	);

	nrm_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (fin & fro),
		.radicand (sq_new),
		.busy     (sq_busy),
		.done     (sq_done),
		.root     (sq_root)
	);

	assign busy       = fin | sq_busy;
	assign done       = done_fast_q | sq_done;
	assign norm_value = sq_done ? nrm_pkg::SUM_W'(sq_root) : res_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	a_fast_result: assert property (@(posedge clk) disable iff (!arst_n)
		(fin && !fro) |=> (done && !sq_busy))
		else $error("missing result after last element");

	a_root_start: assert property (@(posedge clk) disable iff (!arst_n)
		(fin && fro) |=> (sq_busy && !done))
		else $error("square root not started after last element");

endmodule

`default_nettype wire

FILE: verif/tb_matrix_norm_unit.sv
`timescale 1ns / 100ps

module tb_matrix_norm_unit;
	import nrm_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 40;
	localparam int ITEM_TARGET   = 850;
	localparam logic [RIDX_W-1:0] REG_SPARE = 2'd3;

	class norm_scoreboard;
		logic [MODE_W-1:0] mode_reg;
		logic [CNT_W-1:0]  rows_reg;
		logic [CNT_W-1:0]  cols_reg;
		logic [SUM_W-1:0]  col_abs [MAX_COLS];
		logic [SUM_W-1:0]  row_abs;
		logic [SUM_W-1:0]  peak_row;
		logic [SQ_W-1:0]   sq_total;
		int unsigned       row_pos;
		int unsigned       col_pos;
		logic [SUM_W-1:0]  norm_q [$];
		int unsigned       errors;
		int unsigned       results_seen;
		int unsigned       matrices;
		int unsigned       elements;

		function new();
			mode_reg = MODE_ONE;
			rows_reg = 7'd4;
			cols_reg = 7'd4;
			errors = 0;
			results_seen = 0;
			matrices = 0;
			elements = 0;
			clear_matrix();
		endfunction

		function void clear_matrix();
			foreach (col_abs[k])
				col_abs[k] = '0;
			row_abs = '0;
			peak_row = '0;
			sq_total = '0;
			row_pos = 0;
			col_pos = 0;
		endfunction

		function int unsigned effective_count(input logic [CNT_W-1:0] v, input int unsigned top);
			if (v == 0)
				return 1;
			return (32'(v) > top) ? top : 32'(v);
		endfunction

		function logic [ROOT_W-1:0] floor_root(input logic [SQ_W-1:0] v);
			logic [ROOT_W-1:0] r;
			logic [ROOT_W-1:0] t;
			r = '0;
			for (int b = ROOT_W - 1; b >= 0; b--) begin
				t = r | (ROOT_W'(1) << b);
				if (64'(t) * 64'(t) <= 64'(v))
					r = t;
			end
			return r;
		endfunction

		task report(input string msg);
			errors++;
			$display("[%0t] MISMATCH: %s", $realtime, msg);
		endtask

		function void write_reg(input logic [RIDX_W-1:0] idx, input logic [DATA_W-1:0] v);
			case (idx)
				REG_NORM_MODE: mode_reg = v[MODE_W-1:0];
				REG_ROW_COUNT: rows_reg = v[CNT_W-1:0];
				REG_COL_COUNT: cols_reg = v[CNT_W-1:0];
				default: return;
			endcase
			clear_matrix();
		endfunction

		function int unsigned pending();
			return norm_q.size();
		endfunction

		function void note_element(input logic signed [ELEM_W-1:0] e);
			int unsigned n_rows;
			int unsigned n_cols;
			longint unsigned mag;
			longint unsigned norm;
			n_rows = effective_count(rows_reg, MAX_ROWS);
			n_cols = effective_count(cols_reg, MAX_COLS);
			mag = (e < 0) ? longint'(-int'(e)) : longint'(e);
			elements++;
			col_abs[col_pos] += SUM_W'(mag);
			row_abs += SUM_W'(mag);
			sq_total += SQ_W'(mag * mag);
			if (col_pos + 1 < n_cols) begin
				col_pos++;
				return;
			end
			if (row_abs > peak_row)
				peak_row = row_abs;
			row_abs = '0;
			col_pos = 0;
			if (row_pos + 1 < n_rows) begin
				row_pos++;
				return;
			end
			norm = 0;
			case (mode_reg)
				MODE_ONE: begin
					for (int k = 0; k < n_cols; k++)
						if (64'(col_abs[k]) > norm)
							norm = 64'(col_abs[k]);
				end
				MODE_INF: norm = 64'(peak_row);
				MODE_FRO: norm = 64'(floor_root(sq_total));
				default: norm = 0;
			endcase
			if (norm > 64'h3F_FFFF)
				norm = 64'h3F_FFFF;
			norm_q.push_back(SUM_W'(norm));
			matrices++;
			clear_matrix();
		endfunction

		task check_result(input logic [SUM_W-1:0] v);
			logic [SUM_W-1:0] want;
			results_seen++;
			if (norm_q.size() == 0) begin
				report($sformatf("norm_value %0d strobed with no matrix outstanding", v));
				return;
			end
			want = norm_q.pop_front();
			if (v !== want)
				report($sformatf("norm_value %0d, predicted %0d (mode %0d)", v, want, mode_reg));
		endtask
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     start;
	logic signed [ELEM_W-1:0] element;
	logic                     busy;
	logic                     done;
	logic [SUM_W-1:0]         norm_value;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [ADDR_W-1:0]        paddr;
	logic [DATA_W-1:0]        pwdata;
	logic [DATA_W-1:0]        prdata;
	logic                     pready;

	norm_scoreboard sb = new();
	int unsigned    cycle_count = 0;
	int unsigned    sent = 0;
	int unsigned    configs = 0;
	bit             steady = 1'b0;

	matrix_norm_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.element   (element),
		.busy      (busy),
		.done      (done),
		.norm_value(norm_value),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (psel && penable && pwrite && pready)
				sb.write_reg(paddr[ADDR_W-1:2], pwdata);
			if (start && !busy)
				sb.note_element(element);
			if (done)
				sb.check_result(norm_value);
		end
	end

	function automatic logic signed [ELEM_W-1:0] pick_element();
		case ($urandom_range(0, 9))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return '0;
			3: return ELEM_W'($signed($urandom_range(0, 510)) - 255);
			default: return ELEM_W'($urandom());
		endcase
	endfunction

	task automatic apb_xfer(input logic wr, input logic [RIDX_W-1:0] idx,
		input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rdata = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic reg_expect(input logic [RIDX_W-1:0] idx, input logic [DATA_W-1:0] want);
		logic [DATA_W-1:0] rd;
		apb_xfer(1'b0, idx, '0, rd);
		if (rd !== want)
			sb.report($sformatf("register %0d reads %0h, expected %0h", idx, rd, want));
	endtask

	task automatic reg_write(input logic [RIDX_W-1:0] idx, input logic [CNT_W-1:0] v);
		logic [DATA_W-1:0] mask;
		logic [DATA_W-1:0] wdata;
		logic [DATA_W-1:0] rd;
		mask = (idx == REG_NORM_MODE) ? 32'h3 : 32'h7F;
		wdata = ($urandom() & ~mask) | (DATA_W'(v) & mask);
		apb_xfer(1'b1, idx, wdata, rd);
		if (idx != REG_SPARE)
			reg_expect(idx, wdata & mask);
	endtask

	task automatic set_config(input logic [MODE_W-1:0] m, input logic [CNT_W-1:0] r,
		input logic [CNT_W-1:0] c);
		reg_write(REG_NORM_MODE, CNT_W'(m));
		reg_write(REG_ROW_COUNT, r);
		reg_write(REG_COL_COUNT, c);
		configs++;
	endtask

	task automatic send_element(input logic signed [ELEM_W-1:0] v);
		while (!steady && $urandom_range(0, 99) < 13) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		element <= v;
		@(posedge clk);
		while (busy) @(posedge clk);
		sent++;
		steady = (sent >= 300 && sent < 550);
		@(negedge clk);
	endtask

	task automatic settle();
		start <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		logic signed [ELEM_W-1:0] corner_vals [16];
		logic [MODE_W-1:0] m;
		logic [CNT_W-1:0]  r;
		logic [CNT_W-1:0]  c;
		int unsigned       size;
		int unsigned       n_mat;
		int unsigned       part;
		corner_vals = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF, 16'sh0001, 16'sh0100,
			16'shFF00, 16'sh8001, 16'sh5555, 16'shAAAA, 16'sh0080, 16'shFF80,
			16'sh1000, 16'shF000, 16'sh00FF, 16'shFF01};
		arst_n = 1'b0;
		start = 1'b0;
		element = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		reg_expect(REG_NORM_MODE, 32'd0);
		reg_expect(REG_ROW_COUNT, 32'd4);
		reg_expect(REG_COL_COUNT, 32'd4);
		foreach (corner_vals[i])
			send_element(corner_vals[i]);
		settle();

		set_config(2'd3, 7'd1, 7'd1);
		send_element(16'sh7FFF);
		settle();
		set_config(MODE_FRO, 7'd0, 7'd0);
		send_element(16'sh8000);
		settle();

		// spare register must leave the partial row intact
		set_config(MODE_INF, 7'd1, 7'd2);
		send_element(16'sd100);
		settle();
		reg_write(REG_SPARE, CNT_W'($urandom()));
		send_element(-16'sd300);
		settle();

		// mode write drops the partial row
		set_config(MODE_ONE, 7'd1, 7'd2);
		send_element(16'sd5000);
		settle();
		reg_write(REG_NORM_MODE, CNT_W'(MODE_FRO));
		send_element(16'sd3);
		send_element(-16'sd4);
		settle();

		for (int p = 0; sent < ITEM_TARGET; p++) begin
			case (p)
				0: begin m = MODE_ONE; r = 7'd64;  c = 7'd1;   end
				1: begin m = MODE_INF; r = 7'd1;   c = 7'd64;  end
				2: begin m = MODE_FRO; r = 7'd127; c = 7'd1;   end
				3: begin m = MODE_ONE; r = 7'd1;   c = 7'd127; end
				default: begin
					m = ($urandom_range(0, 7) == 7) ? 2'd3 : MODE_W'($urandom_range(0, 2));
					if ($urandom_range(0, 7) == 0) begin
						r = CNT_W'($urandom_range(0, 127));
						c = CNT_W'($urandom_range(1, 2));
						if ($urandom_range(0, 1))
							{r, c} = {c, r};
					end else begin
						r = CNT_W'($urandom_range(0, 6));
						c = CNT_W'($urandom_range(0, 6));
					end
				end
			endcase
			set_config(m, r, c);
			if ($urandom_range(0, 3) == 0)
				reg_write(REG_SPARE, CNT_W'($urandom()));
			size = sb.effective_count(r, MAX_ROWS) * sb.effective_count(c, MAX_COLS);
			n_mat = (size > 40) ? 1 : $urandom_range(1, 4);
			repeat (n_mat * size)
				send_element((p == 0) ? 16'sh8000 : pick_element());
			if (size > 1 && $urandom_range(0, 5) == 0) begin
				part = $urandom_range(1, size - 1);
				repeat (part)
					send_element(pick_element());
			end
			settle();
		end

		if (sb.pending() != 0)
			sb.report($sformatf("%0d predicted norms never strobed", sb.pending()));
		$display("Streamed %0d elements into %0d complete matrices over %0d register settings;",
			sb.elements, sb.matrices, configs);
		$display("%0d norm results compared, %0d errors logged.", sb.results_seen, sb.errors);
		if (sb.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
